>>> src/ppm_pkg.sv
// Shared types and constants for the PPM stream parser.
`default_nettype none
package ppm_pkg;

	localparam int PPM_DIM_BITS = 16;

	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_3     = 8'h33;
	localparam logic [7:0] CH_6     = 8'h36;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [2:0] {
		KIND_WIDTH  = 3'd0,
		KIND_HEIGHT = 3'd1,
		KIND_MAXVAL = 3'd2,
		KIND_SAMPLE = 3'd3,
		KIND_ERROR  = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_MAGIC      = 3'd1,
		ERR_NO_DIGIT   = 3'd2,
		ERR_TERMINATOR = 3'd3,
		ERR_MAXVAL     = 3'd4,
		ERR_OVERFLOW   = 3'd5
	} err_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] value;
		err_t        code;
		logic        last;
	} res_t;

endpackage
`default_nettype wire

>>> src/ppm_in_stage.sv
// Input request register of the PPM parser.
`default_nettype none
module ppm_in_stage
	import ppm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output      logic  in_stall,
	input  wire item_t item,
	input  wire logic  advance,
	output      logic  item_valid,
	output      item_t item_s1
);

	logic valid_s1;
	logic load;

	// Refill when empty or when the held request moves on this cycle.
	assign load       = !valid_s1 || advance;
	assign in_stall   = valid_s1 && !advance;
	assign item_valid = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			item_s1 <= item;
		end
	end

endmodule
`default_nettype wire

>>> src/ppm_parse.sv
// Byte classifier, header tokenizer and sample counter of the PPM parser.
`default_nettype none
module ppm_parse
	import ppm_pkg::*;
#(
	parameter int DIM_BITS = PPM_DIM_BITS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	input  wire item_t item_s1,
	output      logic  res_valid,
	output      res_t  res
);

	localparam int SW = 2 * DIM_BITS + 2;
	localparam int AW = DIM_BITS + 4;
	localparam int VW = (DIM_BITS > 16) ? DIM_BITS : 16;

	typedef enum logic [3:0] {
		PH_MAGIC0 = 4'd0,
		PH_MAGIC1 = 4'd1,
		PH_WIDTH  = 4'd2,
		PH_HEIGHT = 4'd3,
		PH_MAXVAL = 4'd4,
		PH_RAW    = 4'd5,
		PH_ASC    = 4'd6,
		PH_DONE   = 4'd7,
		PH_ERROR  = 4'd8
	} phase_t;

	phase_t                phase_q, ph, ph_n;
	logic                  ascii_q, ascii_n;
	logic                  intok_q, intok, intok_n;
	logic                  incom_q, incom, incom_n;
	logic                  blank_q, blank, blank_n;
	logic [DIM_BITS-1:0]   tok_q, tok_n;
	logic [DIM_BITS-1:0]   width_q;
	logic [2*DIM_BITS-1:0] prod_q;
	logic [SW-1:0]         samples_q, samples_n;

	logic [7:0]    c;
	logic          is_digit, is_ws, is_eol;
	logic [7:0]    dig8;
	logic [3:0]    dig;
	logic [AW-1:0] acc;
	logic [VW-1:0] v_ext;
	logic          width_ld, prod_ld, samples_ld, sample_dec;
	logic          err;
	err_t          err_code;
	logic          last;

	assign c        = item_s1.data_byte;
	assign is_digit = (c >= CH_0) && (c <= CH_9);
	assign is_eol   = (c == CH_LF) || (c == CH_CR);
	assign is_ws    = (c == CH_SPACE) || (c == CH_TAB) || is_eol;
	assign dig8     = c - CH_0;
	assign dig      = dig8[3:0];
	// token * 10 + digit
	assign acc      = AW'({tok_q, 3'b000}) + AW'({tok_q, 1'b0}) + AW'(dig);
	assign v_ext    = VW'(tok_q);
	assign last     = (samples_q == SW'(1));

	// A new file discards all tokenizer state.
	assign ph    = item_s1.file_start ? PH_MAGIC0 : phase_q;
	assign intok = item_s1.file_start ? 1'b0 : intok_q;
	assign incom = item_s1.file_start ? 1'b0 : incom_q;
	assign blank = item_s1.file_start ? 1'b0 : blank_q;

	always_comb begin
		ph_n       = ph;
		ascii_n    = ascii_q;
		intok_n    = intok;
		incom_n    = incom;
		blank_n    = blank;
		tok_n      = tok_q;
		width_ld   = 1'b0;
		prod_ld    = 1'b0;
		samples_ld = 1'b0;
		sample_dec = 1'b0;
		err        = 1'b0;
		err_code   = ERR_NONE;
		res_valid  = 1'b0;
		res        = '{kind: KIND_WIDTH, value: 16'd0, code: ERR_NONE, last: 1'b0};

		unique case (ph)
			PH_MAGIC0: begin
				if (c != CH_P) begin
					err      = 1'b1;
					err_code = ERR_MAGIC;
				end else begin
					ph_n = PH_MAGIC1;
				end
			end
			PH_MAGIC1: begin
				if (c == CH_6 || c == CH_3) begin
					ascii_n = (c == CH_3);
					ph_n    = PH_WIDTH;
					blank_n = 1'b0;
				end else begin
					err      = 1'b1;
					err_code = ERR_MAGIC;
				end
			end
			PH_RAW: begin
				sample_dec = 1'b1;
				res_valid  = 1'b1;
				res.kind   = KIND_SAMPLE;
				res.value  = 16'(c);
				res.last   = last;
				if (last) begin
					ph_n = PH_DONE;
				end
			end
			PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_ASC: begin
				if (incom) begin
					if (is_eol) begin
						incom_n = 1'b0;
						blank_n = 1'b1;
					end
				end else if (intok) begin
					if (is_digit) begin
						if (ph == PH_ASC) begin
							tok_n = DIM_BITS'(acc[7:0]);
						end else if (acc[AW-1:DIM_BITS] != '0) begin
							err      = 1'b1;
							err_code = ERR_OVERFLOW;
						end else begin
							tok_n = acc[DIM_BITS-1:0];
						end
					end else if (is_ws) begin
						// token complete
						intok_n   = 1'b0;
						blank_n   = 1'b1;
						res_valid = 1'b1;
						res.value = v_ext[15:0];
						priority case (ph)
							PH_WIDTH: begin
								width_ld = 1'b1;
								res.kind = KIND_WIDTH;
								ph_n     = PH_HEIGHT;
							end
							PH_HEIGHT: begin
								prod_ld  = 1'b1;
								res.kind = KIND_HEIGHT;
								ph_n     = PH_MAXVAL;
							end
							PH_MAXVAL: begin
								if (v_ext[VW-1:8] != '0) begin
									err      = 1'b1;
									err_code = ERR_MAXVAL;
								end else begin
									samples_ld = 1'b1;
									res.kind   = KIND_MAXVAL;
									if (prod_q == '0) begin
										ph_n = PH_DONE;
									end else begin
										ph_n = ascii_q ? PH_ASC : PH_RAW;
									end
								end
							end
							default: begin
								sample_dec = 1'b1;
								res.kind   = KIND_SAMPLE;
								res.value  = 16'(tok_q[7:0]);
								res.last   = last;
								if (last) begin
									ph_n = PH_DONE;
								end
							end
						endcase
					end else begin
						err      = 1'b1;
						err_code = ERR_TERMINATOR;
					end
				end else if (is_ws) begin
					blank_n = 1'b1;
				end else if (c == CH_HASH && blank) begin
					incom_n = 1'b1;
				end else if (is_digit) begin
					intok_n = 1'b1;
					blank_n = 1'b0;
					tok_n   = DIM_BITS'(dig);
				end else begin
					err      = 1'b1;
					err_code = ERR_NO_DIGIT;
				end
			end
			PH_DONE, PH_ERROR: begin
			end
			default: begin
			end
		endcase

		if (err) begin
			ph_n       = PH_ERROR;
			intok_n    = 1'b0;
			incom_n    = 1'b0;
			samples_ld = 1'b0;
			sample_dec = 1'b0;
			res_valid  = 1'b1;
			res        = '{kind: KIND_ERROR, value: 16'd0, code: err_code, last: 1'b0};
		end

		samples_n = samples_q;
		if (samples_ld) begin
			samples_n = SW'({prod_q, 1'b0}) + SW'(prod_q);
		end else if (sample_dec) begin
			samples_n = samples_q - SW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC0;
			ascii_q <= 1'b0;
			intok_q <= 1'b0;
			incom_q <= 1'b0;
			blank_q <= 1'b0;
		end else if (item_valid) begin
			phase_q <= ph_n;
			ascii_q <= ascii_n;
			intok_q <= intok_n;
			incom_q <= incom_n;
			blank_q <= blank_n;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid) begin
			tok_q     <= tok_n;
			samples_q <= samples_n;
			if (width_ld) begin
				width_q <= tok_q;
			end
			if (prod_ld) begin
				prod_q <= width_q * tok_q;
			end
		end
	end

`ifndef SYNTH
	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RAW || phase_q == PH_ASC) |-> samples_q != '0)
		else $error("sample phase with zero samples left");

	a_tok_com_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(intok_q && incom_q))
		else $error("token and comment active together");

	a_err_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && res_valid && res.kind == KIND_ERROR) |=> phase_q == PH_ERROR)
		else $error("error result did not stop parser");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && res_valid && res.last) |=> phase_q == PH_DONE)
		else $error("final sample did not finish image");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.last) |-> (res.kind == KIND_SAMPLE && last))
		else $error("last flag outside final sample");
`endif

endmodule
`default_nettype wire

>>> src/ppm_out_stage.sv
// Result register of the PPM parser.
`default_nettype none
module ppm_out_stage
	import ppm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	input  wire logic res_valid,
	input  wire res_t res,
	input  wire logic out_stall,
	output      logic advance,
	output      logic out_valid,
	output      res_t res_q
);

	logic out_valid_q;

	assign advance   = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= item_valid && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_valid && res_valid) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

>>> src/ppm_image_stream_parser.sv
// Top level of the PPM (P3/P6) image stream parser.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | data_byte[7:0], file_start
//  out     | out_valid / out_stall| kind[2:0], value[15:0], error_code[2:0],
//          |                      | last_sample
//
// One byte request is taken per cycle unless a stall on out backs up. A byte
// accepted sits in the input register, and its result, if it yields one, is
// loaded into the result register when that register can advance. The
// per-byte work (classify, multiply by ten and add, header/sample bookkeeping)
// sits between those registers.
// Reset clears the handshake and parser control state; no clearing pass.
// A stall on out holds the result register and backs up into in_stall.
// file_start on a byte restarts the parser from that byte.
`default_nettype none
module ppm_image_stream_parser
	import ppm_pkg::*;
#(
	parameter int DIM_BITS = PPM_DIM_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        file_start,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [2:0]  kind,
	output      logic [15:0] value,
	output      logic [2:0]  error_code,
	output      logic        last_sample
);

	item_t item, item_s1;
	logic  advance;
	logic  item_valid;
	logic  res_valid;
	res_t  res, res_q;

	assign item.data_byte  = data_byte;
	assign item.file_start = file_start;

	ppm_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.item       (item),
		.advance    (advance),
		.item_valid (item_valid),
		.item_s1    (item_s1)
	);

	ppm_parse #(
		.DIM_BITS (DIM_BITS)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_s1    (item_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	ppm_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.res_valid  (res_valid),
		.res        (res),
		.out_stall  (out_stall),
		.advance    (advance),
		.out_valid  (out_valid),
		.res_q      (res_q)
	);

	// Unpack the registered result onto the output ports.
	assign kind        = res_q.kind;
	assign value       = res_q.value;
	assign error_code  = res_q.code;
	assign last_sample = res_q.last;

endmodule
`default_nettype wire

>>> tb/ppm_image_stream_parser_check.sv
// Result checker for the PPM stream parser: predicts the parser's output per byte request and compares it.
`timescale 1ns / 100ps
module ppm_image_stream_parser_check
	import ppm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        file_start,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  kind,
	input  logic [15:0] value,
	input  logic [2:0]  error_code,
	input  logic        last_sample,
	input  logic        drained,
	output int          mismatches,
	output int          records_pending
);

	localparam int unsigned HEADER_MAX = (1 << PPM_DIM_BITS) - 1;
	localparam int unsigned SAMPLE_MAX = 255;

	typedef enum logic [3:0] {
		ST_MAGIC_P,
		ST_MAGIC_NUM,
		ST_WIDTH,
		ST_HEIGHT,
		ST_MAXVAL,
		ST_RAW,
		ST_ASCII,
		ST_DONE,
		ST_HALT
	} parse_state_t;

	parse_state_t state = ST_MAGIC_P;
	logic         ascii_mode = 1'b0;
	logic [16:0]  token = '0;
	logic         in_token = 1'b0;
	logic         in_comment = 1'b0;
	logic         after_blank = 1'b0;
	logic [15:0]  img_width = '0;
	logic [15:0]  img_height = '0;
	logic [33:0]  samples_left = '0;

	res_t  parsed_records[$];
	res_t  want;
	string diffs;
	int    fail_count = 0;
	int    pending = 0;
	bit    leftover_seen = 1'b0;

	assign mismatches      = fail_count;
	assign records_pending = pending;

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: %s", $time, what);
		fail_count++;
	endtask

	task automatic restart_parser();
		state        = ST_MAGIC_P;
		ascii_mode   = 1'b0;
		token        = '0;
		in_token     = 1'b0;
		in_comment   = 1'b0;
		after_blank  = 1'b0;
		img_width    = '0;
		img_height   = '0;
		samples_left = '0;
	endtask

	task automatic push_record(input kind_t k, input logic [15:0] v, input err_t ec,
			input logic last);
		parsed_records.push_back('{kind: k, value: v, code: ec, last: last});
	endtask

	task automatic halt_with(input err_t ec);
		state      = ST_HALT;
		in_token   = 1'b0;
		in_comment = 1'b0;
		push_record(KIND_ERROR, 16'h0000, ec, 1'b0);
	endtask

	task automatic emit_sample(input logic [7:0] v);
		samples_left = samples_left - 34'd1;
		if (samples_left == 34'd0)
			state = ST_DONE;
		push_record(KIND_SAMPLE, {8'h00, v}, ERR_NONE, samples_left == 34'd0);
	endtask

	task automatic parse_byte(input logic [7:0] c, input logic restart);
		logic [19:0] acc;
		logic [16:0] num;
		if (restart)
			restart_parser();
		case (state)
			ST_MAGIC_P: begin
				if (c == CH_P)
					state = ST_MAGIC_NUM;
				else
					halt_with(ERR_MAGIC);
			end
			ST_MAGIC_NUM: begin
				if (c == CH_6 || c == CH_3) begin
					ascii_mode  = (c == CH_3);
					state       = ST_WIDTH;
					after_blank = 1'b0;
				end else begin
					halt_with(ERR_MAGIC);
				end
			end
			ST_RAW: begin
				emit_sample(c);
			end
			ST_WIDTH, ST_HEIGHT, ST_MAXVAL, ST_ASCII: begin
				if (in_comment) begin
					if (c == CH_LF || c == CH_CR) begin
						in_comment  = 1'b0;
						after_blank = 1'b1;
					end
				end else if (in_token && is_digit(c)) begin
					acc = token * 10 + (c - CH_0);
					// sample tokens wrap at 8 bits, header numbers trap on overflow
					if (state == ST_ASCII)
						token = {9'b0, acc[7:0]};
					else if (acc > HEADER_MAX)
						halt_with(ERR_OVERFLOW);
					else
						token = acc[16:0];
				end else if (in_token && is_blank(c)) begin
					num         = token;
					in_token    = 1'b0;
					after_blank = 1'b1;
					token       = '0;
					case (state)
						ST_WIDTH: begin
							img_width = num[15:0];
							state     = ST_HEIGHT;
							push_record(KIND_WIDTH, num[15:0], ERR_NONE, 1'b0);
						end
						ST_HEIGHT: begin
							img_height = num[15:0];
							state      = ST_MAXVAL;
							push_record(KIND_HEIGHT, num[15:0], ERR_NONE, 1'b0);
						end
						ST_MAXVAL: begin
							if (num > SAMPLE_MAX) begin
								halt_with(ERR_MAXVAL);
							end else begin
								samples_left = img_width * img_height * 3;
								if (samples_left == 34'd0)
									state = ST_DONE;
								else if (ascii_mode)
									state = ST_ASCII;
								else
									state = ST_RAW;
								push_record(KIND_MAXVAL, num[15:0], ERR_NONE, 1'b0);
							end
						end
						default: begin
							emit_sample(num[7:0]);
						end
					endcase
				end else if (in_token) begin
					halt_with(ERR_TERMINATOR);
				end else if (is_blank(c)) begin
					after_blank = 1'b1;
				end else if (c == CH_HASH && after_blank) begin
					in_comment = 1'b1;
				end else if (is_digit(c)) begin
					in_token    = 1'b1;
					after_blank = 1'b0;
					token       = c - CH_0;
				end else begin
					halt_with(ERR_NO_DIGIT);
				end
			end
			default: begin
				// done or halted: bytes are dropped until the next file start
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parsed_records.delete();
			restart_parser();
		end else begin
			if (in_valid && !in_stall)
				parse_byte(data_byte, file_start);
			if (out_valid && !out_stall) begin
				if (parsed_records.size() == 0) begin
					report_mismatch($sformatf("unexpected result: kind %0d value %0h code %0d last %0b",
						kind, value, error_code, last_sample));
				end else begin
					want  = parsed_records.pop_front();
					diffs = "";
					if (kind !== want.kind)
						diffs = {diffs, $sformatf(" kind %0d/%0d", kind, want.kind)};
					if (value !== want.value)
						diffs = {diffs, $sformatf(" value %0h/%0h", value, want.value)};
					if (error_code !== want.code)
						diffs = {diffs, $sformatf(" code %0d/%0d", error_code, want.code)};
					if (last_sample !== want.last)
						diffs = {diffs, $sformatf(" last %0b/%0b", last_sample, want.last)};
					if (diffs != "")
						report_mismatch({"result differs (seen/predicted):", diffs});
				end
			end
			if (drained && !leftover_seen && parsed_records.size() != 0) begin
				leftover_seen = 1'b1;
				report_mismatch($sformatf("%0d predicted results never arrived",
					parsed_records.size()));
			end
		end
		pending = parsed_records.size();
	end

endmodule

>>> tb/ppm_image_stream_parser_test.sv
// Testbench top for the PPM stream parser: clock, reset, file stimulus, flow control and verdict.
`timescale 1ns / 100ps
module ppm_image_stream_parser_test;
	import ppm_pkg::*;

	localparam int unsigned HEADER_MAX   = (1 << PPM_DIM_BITS) - 1;
	localparam int          ITEM_TARGET  = 650;
	// a result trails its byte through the input and result registers; leave some slack on top
	localparam int          TAIL_CYCLES  = 6;
	localparam int          DRAIN_CYCLES = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        file_start = 1'b0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [2:0]  kind;
	logic [15:0] value;
	logic [2:0]  error_code;
	logic        last_sample;
	logic        drained = 1'b0;
	int          mismatches;
	int          records_pending;

	// percent chances of a sender gap / receiver stall in a given cycle
	int          gap_pct = 0;
	int          stall_pct = 0;

	// bytes of the file being assembled, sent as one burst of requests
	logic [7:0]  file_bytes[$];
	int          sent_bytes = 0;

	always #4 clk = ~clk;

	ppm_image_stream_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.file_start (file_start),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.value      (value),
		.error_code (error_code),
		.last_sample(last_sample)
	);

	ppm_image_stream_parser_check results_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.file_start     (file_start),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.value          (value),
		.error_code     (error_code),
		.last_sample    (last_sample),
		.drained        (drained),
		.mismatches     (mismatches),
		.records_pending(records_pending)
	);

	// Receiver side: stall is drawn fresh every cycle, independent of out_valid.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			default: return CH_CR;
		endcase
	endfunction

	task automatic put_text(input string s);
		foreach (s[i])
			file_bytes.push_back(s[i]);
	endtask

	// Token separator: one or two whitespace bytes, sometimes followed by a comment.
	task automatic put_gap();
		logic [7:0] c;
		repeat ($urandom_range(2, 1))
			file_bytes.push_back(pick_blank());
		// '#' right after whitespace opens a comment that runs to the next LF or CR
		if ($urandom_range(4) == 0) begin
			file_bytes.push_back(CH_HASH);
			repeat ($urandom_range(5)) begin
				c = $urandom_range(255);
				if (c == CH_LF || c == CH_CR)
					c = CH_HASH;
				file_bytes.push_back(c);
			end
			file_bytes.push_back($urandom_range(1) ? CH_LF : CH_CR);
		end
	endtask

	task automatic put_number(input int unsigned v);
		string digits;
		// a leading zero leaves the value alone but lengthens the digit run
		if ($urandom_range(5) == 0)
			file_bytes.push_back(CH_0);
		digits = $sformatf("%0d", v);
		foreach (digits[i])
			file_bytes.push_back(digits[i]);
	endtask

	// Assemble one random file. Most are well-formed tiny images with random
	// whitespace, comments and sample content; the rest are noise, oversize
	// numbers, corrupted bytes, or files cut short so that the next file start
	// lands mid-parse. live counts the bytes the parser actually works on.
	task automatic build_file(output int live);
		int unsigned w, h, mv, total, big;
		int          style, cut;
		bit          ascii;
		style = $urandom_range(99);
		ascii = $urandom_range(1);
		if (style < 7) begin
			// line noise: almost always a bad magic
			repeat ($urandom_range(8, 1))
				file_bytes.push_back($urandom_range(255));
		end else begin
			w  = $urandom_range(3, 1);
			h  = $urandom_range(2, 1);
			mv = $urandom_range(255);
			case ($urandom_range(9))
				0: mv = 255;
				1: mv = 0;
				2: mv = 1;
				default: ;
			endcase
			// empty image: header only, the other side may be as large as allowed
			if ($urandom_range(9) == 0) begin
				if ($urandom_range(1)) begin
					w = 0;
					h = $urandom_range(1) ? HEADER_MAX : $urandom_range(9);
				end else begin
					h = 0;
					w = $urandom_range(1) ? HEADER_MAX : $urandom_range(9);
				end
			end
			if (style < 13) begin
				mv = $urandom_range(HEADER_MAX, 256);
			end else if (style < 18) begin
				// header number past 16 bits, trapped at the crossing digit
				big = $urandom_range(1) ? HEADER_MAX + 1 : HEADER_MAX + 1 + $urandom_range(1000000);
				case ($urandom_range(2))
					0: w = big;
					1: h = big;
					default: mv = big;
				endcase
			end
			if (w > HEADER_MAX || h > HEADER_MAX || mv > 255)
				total = 0;
			else
				total = w * h * 3;

			put_text(ascii ? "P3" : "P6");
			// the first number may follow the magic directly
			if ($urandom_range(7) != 0)
				put_gap();
			put_number(w);
			put_gap();
			put_number(h);
			put_gap();
			put_number(mv);
			// exactly one whitespace byte ends maxval; raw samples start right after
			file_bytes.push_back(pick_blank());
			repeat (total) begin
				if (!ascii) begin
					file_bytes.push_back($urandom_range(255));
				end else begin
					if ($urandom_range(3) == 0)
						put_gap();
					put_number($urandom_range(7) == 0 ? $urandom_range(99999) : $urandom_range(999));
					file_bytes.push_back(pick_blank());
				end
			end

			if (style >= 18 && style < 30) begin
				file_bytes[$urandom_range(file_bytes.size() - 1)] = $urandom_range(255);
			end else if (style >= 30 && style < 38) begin
				cut = $urandom_range(file_bytes.size() - 1, 1);
				while (file_bytes.size() > cut)
					void'(file_bytes.pop_back());
			end
		end
		live = file_bytes.size();
		// trailing bytes after an image or an error are dropped by the parser
		if ($urandom_range(4) == 0)
			repeat ($urandom_range(4, 1))
				file_bytes.push_back($urandom_range(255));
	endtask

	// One byte request. valid stays high from one request to the next unless a
	// gap is drawn, so it is never dropped and raised in the same time step.
	task automatic send_byte(input logic [7:0] b, input logic restart);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		file_start <= restart;
		do begin
			@(posedge clk);
		end while (in_stall);
	endtask

	// The first byte of each file carries file_start.
	task automatic send_file();
		foreach (file_bytes[i])
			send_byte(file_bytes[i], i == 0);
		file_bytes.delete();
	endtask

	initial begin
		int live;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed files, free flowing: bad first magic byte, bad second magic
		// byte, a '#' straight after the magic, a digit run ended by a letter,
		// a width past 16 bits, and an empty P3 image whose width is the
		// largest header number.
		put_text("X");
		send_file();
		put_text("P7");
		send_file();
		put_text("P6#");
		send_file();
		put_text("P6\t9q");
		send_file();
		put_text("P6 70000");
		send_file();
		put_text("P3 65535\t0 255 ");
		send_file();

		// Random files, each under a traffic pattern of its own.
		while (sent_bytes < ITEM_TARGET) begin
			case ($urandom_range(3))
				0: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct   = 51;
					stall_pct = 0;
				end
				2: begin
					gap_pct   = 0;
					stall_pct = 51;
				end
				default: begin
					gap_pct   = 18;
					stall_pct = 18;
				end
			endcase
			build_file(live);
			sent_bytes += live;
			send_file();
		end
		in_valid <= 1'b0;
		// let the checker take the last accepted byte before counting what is owed
		@(posedge clk);

		// Drain: wait for every predicted result, bounded, then a short tail so
		// that any stray extra result shows up before the verdict.
		for (int n = 0; n < DRAIN_CYCLES && records_pending != 0; n++)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		drained <= 1'b1;
		repeat (2) @(posedge clk);

		if (mismatches == 0) begin
			$display("PASS ppm_image_stream_parser");
		end else begin
			$display("FAIL ppm_image_stream_parser");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#(2_000_000);
		$display("FAIL ppm_image_stream_parser");
		$finish;
	end

endmodule

>>> sim.f
src/ppm_pkg.sv
src/ppm_in_stage.sv
src/ppm_parse.sv
src/ppm_out_stage.sv
src/ppm_image_stream_parser.sv
tb/ppm_image_stream_parser_check.sv
tb/ppm_image_stream_parser_test.sv
